// ----- rtl/ihrc_pkg.sv -----
// ihrc_pkg: shared types, constants and reset values for the hex record checker
// used by ihrc_line_parser, ihrc_out_queue and intel_hex_record_checker
`default_nettype none

package ihrc_pkg;

  // page size of the address map and line length limit
  localparam int PAGE_SHIFT     = 10;
  localparam int MAX_LINE_BYTES = 256;

  // bytes allowed after the four header bytes
  localparam logic [7:0] BODY_LIMIT = 8'(MAX_LINE_BYTES - 4);

  // header length in characters, colon included
  localparam logic [3:0] HEAD_LEN = 4'd9;

  // line phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_TAIL = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_HEADER   = 3'd1;
  localparam logic [2:0] ERR_DIGIT    = 3'd2;
  localparam logic [2:0] ERR_CHECKSUM = 3'd3;
  localparam logic [2:0] ERR_GAP      = 3'd4;
  localparam logic [2:0] ERR_FILE_BAD = 3'd5;
  localparam logic [2:0] ERR_TOO_LONG = 3'd6;

  // characters of interest
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_FIVE  = 8'h35;

  typedef struct packed {
    logic [1:0]  phase;
    logic [3:0]  head_pos;
    logic [3:0]  nibble_hold;
    logic        digit_odd;
    logic [7:0]  byte_sum;
    logic [7:0]  bytes_in_line;
    logic [15:0] header_address;
    logic [2:0]  header_type;
    logic [2:0]  line_error;
  } line_state_t;

  typedef struct packed {
    logic        file_good;
    logic        seen_data;
    logic [16:0] expected_next;
    logic [15:0] lowest_address;
    logic [15:0] highest_address;
    logic [63:0] page_map;
  } file_state_t;

  typedef struct packed {
    logic        line_ok;
    logic [2:0]  error_code;
    logic [15:0] record_address;
    logic [2:0]  record_type;
    logic [7:0]  data_bytes;
    logic        file_valid;
    logic [15:0] first_address;
    logic [15:0] last_address;
    logic [63:0] pages_used;
  } result_t;

  localparam line_state_t LINE_CLEAR = '{
    phase:          PH_IDLE,
    head_pos:       4'd0,
    nibble_hold:    4'd0,
    digit_odd:      1'b0,
    byte_sum:       8'd0,
    bytes_in_line:  8'd0,
    header_address: 16'd0,
    header_type:    3'd0,
    line_error:     ERR_NONE
  };

  localparam file_state_t FILE_CLEAR = '{
    file_good:       1'b1,
    seen_data:       1'b0,
    expected_next:   17'd0,
    lowest_address:  16'hFFFF,
    highest_address: 16'd0,
    page_map:        64'd0
  };

endpackage

`default_nettype wire

// ----- rtl/ihrc_line_parser.sv -----
// ihrc_line_parser: per-character line checking and per-file tracking state
// depends on ihrc_pkg
`default_nettype none

module ihrc_line_parser (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   accept,
  input  wire  [7:0]            char_code,
  input  wire                   file_start,
  input  wire                   file_end,
  output ihrc_pkg::result_t     result,
  output logic                  result_push
);

  ihrc_pkg::line_state_t lstate, lstate_next;
  ihrc_pkg::file_state_t fstate, fstate_next;

  logic       is_space;
  logic [4:0] hex_up;
  logic [4:0] hex_any;
  logic [3:0] head_pos_sel;
  logic       head_good;
  logic       take;
  logic       in_body;
  logic       byte_done;
  logic       do_end;
  logic [2:0] code;
  logic [7:0] data;
  logic [5:0] page_idx;

  // hex decode: {valid, digit}
  function automatic logic [4:0] hex_decode(input logic [7:0] c, input logic lower_ok);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (lower_ok && (c inside {[8'h61:8'h66]})) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  assign is_space = (char_code inside {8'h20, 8'h09, 8'h0D, 8'h0B, 8'h0C});
  assign hex_up   = hex_decode(char_code, 1'b0);
  assign hex_any  = hex_decode(char_code, 1'b1);
  assign do_end   = (char_code == ihrc_pkg::CH_LF) || file_end;

  // header position after an optional file clear, which restarts at zero
  assign head_pos_sel = file_start ? 4'd0 : lstate.head_pos;

  // header position check
  always_comb begin
    case (head_pos_sel)
      4'd0:    head_good = (char_code == ihrc_pkg::CH_COLON);
      4'd1:    head_good = (char_code == ihrc_pkg::CH_ZERO) || (char_code == ihrc_pkg::CH_ONE);
      4'd7:    head_good = (char_code == ihrc_pkg::CH_ZERO);
      4'd8:    head_good = (char_code inside {[ihrc_pkg::CH_ZERO:ihrc_pkg::CH_FIVE]});
      default: head_good = hex_up[4];
    endcase
  end

  // next state and result for one word
  always_comb begin
    lstate_next = file_start ? ihrc_pkg::LINE_CLEAR : lstate;
    fstate_next = file_start ? ihrc_pkg::FILE_CLEAR : fstate;
    take        = 1'b0;
    in_body     = 1'b0;
    byte_done   = 1'b0;
    code        = ihrc_pkg::ERR_NONE;
    data        = 8'd0;
    page_idx    = 6'd0;
    result      = '0;
    result_push = 1'b0;

    // character within a line
    if (char_code != ihrc_pkg::CH_LF) begin
      if (!(lstate_next.phase == ihrc_pkg::PH_IDLE && is_space)) begin
        if (lstate_next.phase == ihrc_pkg::PH_IDLE) begin
          lstate_next.phase = ihrc_pkg::PH_HEAD;
        end
        if (lstate_next.line_error == ihrc_pkg::ERR_NONE) begin
          if (is_space) begin
            lstate_next.phase = ihrc_pkg::PH_TAIL;
          end else if (lstate_next.phase == ihrc_pkg::PH_TAIL) begin
            lstate_next.line_error = (lstate_next.head_pos < ihrc_pkg::HEAD_LEN) ?
                                     ihrc_pkg::ERR_HEADER : ihrc_pkg::ERR_DIGIT;
          end else if (lstate_next.phase == ihrc_pkg::PH_HEAD) begin
            if (!head_good) begin
              lstate_next.line_error = ihrc_pkg::ERR_HEADER;
            end else begin
              take = (lstate_next.head_pos != 4'd0);
              if (lstate_next.head_pos >= 4'd3 && lstate_next.head_pos <= 4'd6) begin
                lstate_next.header_address = {lstate_next.header_address[11:0], hex_up[3:0]};
              end
              if (lstate_next.head_pos == 4'd8) begin
                lstate_next.header_type = hex_up[2:0];
              end
              lstate_next.head_pos = 4'(lstate_next.head_pos + 4'd1);
              if (lstate_next.head_pos >= ihrc_pkg::HEAD_LEN) begin
                lstate_next.phase = ihrc_pkg::PH_BODY;
              end
            end
          end else begin
            if (!hex_any[4]) begin
              lstate_next.line_error = ihrc_pkg::ERR_DIGIT;
            end else begin
              take    = 1'b1;
              in_body = 1'b1;
            end
          end
        end
      end
    end

    // byte assembly
    if (take) begin
      if (!lstate_next.digit_odd) begin
        lstate_next.nibble_hold = in_body ? hex_any[3:0] : hex_up[3:0];
        lstate_next.digit_odd   = 1'b1;
      end else begin
        lstate_next.byte_sum  = lstate_next.byte_sum +
                                {lstate_next.nibble_hold, (in_body ? hex_any[3:0] : hex_up[3:0])};
        lstate_next.digit_odd = 1'b0;
        byte_done             = 1'b1;
      end
    end

    // body byte count and length limit
    if (in_body && byte_done) begin
      if (lstate_next.bytes_in_line >= ihrc_pkg::BODY_LIMIT) begin
        lstate_next.line_error = ihrc_pkg::ERR_TOO_LONG;
      end else begin
        lstate_next.bytes_in_line = lstate_next.bytes_in_line + 8'd1;
      end
    end

    // line end: final checks, file tracking, result
    if (do_end && lstate_next.phase != ihrc_pkg::PH_IDLE) begin
      data = (lstate_next.bytes_in_line != 8'd0) ? lstate_next.bytes_in_line - 8'd1 : 8'd0;
      code = lstate_next.line_error;
      if (code == ihrc_pkg::ERR_NONE) begin
        if (lstate_next.head_pos < ihrc_pkg::HEAD_LEN) begin
          code = ihrc_pkg::ERR_HEADER;
        end else if (lstate_next.digit_odd) begin
          code = ihrc_pkg::ERR_DIGIT;
        end else if (lstate_next.bytes_in_line == 8'd0) begin
          code = ihrc_pkg::ERR_HEADER;
        end else if (lstate_next.byte_sum != 8'd0) begin
          code = ihrc_pkg::ERR_CHECKSUM;
        end else if (lstate_next.header_type == 3'd0 && fstate_next.seen_data &&
                     {1'b0, lstate_next.header_address} != fstate_next.expected_next) begin
          code = ihrc_pkg::ERR_GAP;
        end
      end
      if (!fstate_next.file_good) begin
        code = ihrc_pkg::ERR_FILE_BAD;
      end
      page_idx = 6'((lstate_next.header_address >> ihrc_pkg::PAGE_SHIFT) & 16'd63);
      if (code != ihrc_pkg::ERR_NONE) begin
        fstate_next.file_good = 1'b0;
      end else if (lstate_next.header_type == 3'd0) begin
        fstate_next.seen_data     = 1'b1;
        fstate_next.expected_next = {1'b0, lstate_next.header_address} + {9'd0, data};
        if (lstate_next.header_address < fstate_next.lowest_address) begin
          fstate_next.lowest_address = lstate_next.header_address;
        end
        if (lstate_next.header_address > fstate_next.highest_address) begin
          fstate_next.highest_address = lstate_next.header_address;
        end
        fstate_next.page_map = fstate_next.page_map | (64'd1 << page_idx);
      end
      result.line_ok        = (code == ihrc_pkg::ERR_NONE);
      result.error_code     = code;
      result.record_address = lstate_next.header_address;
      result.record_type    = lstate_next.header_type;
      result.data_bytes     = data;
      result.file_valid     = fstate_next.file_good;
      result.first_address  = fstate_next.lowest_address;
      result.last_address   = fstate_next.highest_address;
      result.pages_used     = fstate_next.page_map;
      result_push           = accept;
      lstate_next           = ihrc_pkg::LINE_CLEAR;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lstate <= ihrc_pkg::LINE_CLEAR;
      fstate <= ihrc_pkg::FILE_CLEAR;
    end else if (accept) begin
      lstate <= lstate_next;
      fstate <= fstate_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ihrc_out_queue.sv -----
// ihrc_out_queue: two-entry result queue that parts the input and output sides
// depends on ihrc_pkg
`default_nettype none

module ihrc_out_queue (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  wire ihrc_pkg::result_t push_data,
  input  wire                pop_ready,
  output logic               pop_valid,
  output ihrc_pkg::result_t  pop_data,
  output logic               has_space
);

  ihrc_pkg::result_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop_valid = (count != 2'd0);
  assign pop_data  = entries[rd_ptr];
  assign has_space = (count != 2'd2);
  assign pop       = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/intel_hex_record_checker.sv -----
// intel_hex_record_checker: top level, checks hex file text one character per word
// depends on ihrc_pkg, ihrc_line_parser, ihrc_out_queue
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   char    | char_valid, char_ready  | char_code, file_start, file_end
//   line    | line_valid, line_ready  | line_ok .. pages_used, line_last
//
// one character is taken per cycle while char_ready is high
// the parser state updates at the accepting edge, the result lands in a 2-entry queue
// char_ready drops only while the queue holds two results
// rst (synchronous) clears line and file state and empties the queue
`default_nettype none

module intel_hex_record_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         char_valid,
  output logic        char_ready,
  input  wire  [7:0]  char_code,
  input  wire         file_start,
  input  wire         file_end,
  output logic        line_valid,
  input  wire         line_ready,
  output logic        line_ok,
  output logic [2:0]  error_code,
  output logic [15:0] record_address,
  output logic [2:0]  record_type,
  output logic [7:0]  data_bytes,
  output logic        file_valid,
  output logic [15:0] first_address,
  output logic [15:0] last_address,
  output logic [63:0] pages_used,
  output logic        line_last
);

  ihrc_pkg::result_t parse_result;
  ihrc_pkg::result_t head_result;
  logic              parse_push;
  logic              accept;

  assign accept = char_valid && char_ready;

  // line checking and file tracking
  ihrc_line_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_code   (char_code),
    .file_start  (file_start),
    .file_end    (file_end),
    .result      (parse_result),
    .result_push (parse_push)
  );

  // result queue
  ihrc_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (parse_push),
    .push_data (parse_result),
    .pop_ready (line_ready),
    .pop_valid (line_valid),
    .pop_data  (head_result),
    .has_space (char_ready)
  );

  // result word fields
  assign line_ok        = head_result.line_ok;
  assign error_code     = head_result.error_code;
  assign record_address = head_result.record_address;
  assign record_type    = head_result.record_type;
  assign data_bytes     = head_result.data_bytes;
  assign file_valid     = head_result.file_valid;
  assign first_address  = head_result.first_address;
  assign last_address   = head_result.last_address;
  assign pages_used     = head_result.pages_used;
  assign line_last      = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/ihrc_checker.sv -----
// ihrc_checker: port-level assertions for intel_hex_record_checker, with its bind
// depends on ihrc_pkg
`default_nettype none

module ihrc_checker (
  input wire        clk,
  input wire        rst,
  input wire        line_valid,
  input wire        line_ready,
  input wire        line_ok,
  input wire [2:0]  error_code,
  input wire [15:0] record_address,
  input wire        file_valid,
  input wire        line_last
);

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    line_valid && !line_ready |=> line_valid && $stable(error_code) &&
                                  $stable(record_address))
    else $error("result word changed while stalled");

  // pass flag agrees with the error code
  a_ok_code: assert property (@(posedge clk) disable iff (rst)
    line_valid |-> (line_ok == (error_code == ihrc_pkg::ERR_NONE)))
    else $error("line_ok disagrees with error_code");

  // a line passes exactly when the file is still good after it
  a_ok_file: assert property (@(posedge clk) disable iff (rst)
    line_valid |-> (line_ok == file_valid))
    else $error("line_ok disagrees with file_valid");

  // every result word closes its line
  a_last: assert property (@(posedge clk) disable iff (rst)
    line_valid |-> line_last)
    else $error("line_last low on a result word");

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !line_valid)
    else $error("result word present after reset");

endmodule

bind intel_hex_record_checker ihrc_checker u_ihrc_checker (
  .clk            (clk),
  .rst            (rst),
  .line_valid     (line_valid),
  .line_ready     (line_ready),
  .line_ok        (line_ok),
  .error_code     (error_code),
  .record_address (record_address),
  .file_valid     (file_valid),
  .line_last      (line_last)
);

`default_nettype wire
